// File: src/fbfl_pkg.sv
package fbfl_pkg;

    // Pool geometry
    localparam int MAX_BLOCKS   = 256;
    localparam int IDX_W        = $clog2(MAX_BLOCKS);
    localparam int CNT_W        = $clog2(MAX_BLOCKS + 1);
    localparam int WORD_BYTES   = 8;
    localparam int HEADER_WORDS = 3;
    localparam int BYTES_LIMIT  = 4096;

    // Field widths
    localparam int BYTES_W  = 13;
    localparam int OFFSET_W = 20;
    localparam int CFG_W    = 13;
    localparam int STRIDE_W = 13;
    localparam int PROD_W   = IDX_W + STRIDE_W;

    // The user area of block i starts one header word after the block start
    localparam logic [PROD_W-1:0] USER_BASE = PROD_W'((HEADER_WORDS + 1) * WORD_BYTES);

    typedef enum logic
    {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } opcode_t;

    typedef enum logic [1:0]
    {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_RANGE     = 2'd2,
        ST_NOT_ALLOC = 2'd3
    } status_t;

    typedef enum logic
    {
        CFG_BLOCK_BYTES = 1'b0,
        CFG_BLOCK_COUNT = 1'b1
    } cfg_index_t;

    // Control from the allocator to the free stack
    typedef struct packed
    {
        logic             rebuild;
        logic             wr_en;
        logic [IDX_W-1:0] wr_pos;
        logic [IDX_W-1:0] wr_data;
        logic [IDX_W-1:0] rd_pos;
        logic [CNT_W-1:0] count;
    } stack_ctrl_t;

    // Block count as the pool uses it: zero counts as one, excess clamps to MAX_BLOCKS
    function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] raw);
        logic [CNT_W-1:0] c;
        c = raw;
        if (c == '0)
        begin
            c = CNT_W'(1);
        end
        if (c > CNT_W'(MAX_BLOCKS))
        begin
            c = CNT_W'(MAX_BLOCKS);
        end
        return c;
    endfunction

    // Distance between user areas: clamped, rounded user size plus header word
    function automatic logic [STRIDE_W-1:0] block_stride(input logic [BYTES_W-1:0] raw);
        logic [BYTES_W-1:0] b;
        logic [BYTES_W-1:0] r;
        b = raw;
        if (b > BYTES_W'(BYTES_LIMIT))
        begin
            b = BYTES_W'(BYTES_LIMIT);
        end
        r = (b + BYTES_W'(WORD_BYTES - 1)) & ~BYTES_W'(WORD_BYTES - 1);
        return STRIDE_W'(r) + STRIDE_W'(WORD_BYTES);
    endfunction

endpackage

// File: src/fbfl_if.sv
interface fbfl_req_if
    import fbfl_pkg::*;
();
    logic             valid;
    logic             ready;
    opcode_t          opcode;
    logic [IDX_W-1:0] block_index;

    modport source (output valid, output opcode, output block_index, input ready);
    modport sink   (input valid, input opcode, input block_index, output ready);
endinterface

interface fbfl_rsp_if
    import fbfl_pkg::*;
();
    logic                valid;
    logic                ready;
    status_t             status;
    logic [IDX_W-1:0]    granted_index;
    logic [OFFSET_W-1:0] user_offset;
    logic [CNT_W-1:0]    free_count;

    modport source (output valid, output status, output granted_index,
                    output user_offset, output free_count, input ready);
    modport sink   (input valid, input status, input granted_index,
                    input user_offset, input free_count, output ready);
endinterface

// File: src/fixed_block_free_list_allocator.sv
// A request accepted into the input stage is decided there once the result
// stage can take it; its result is then registered and held valid until taken.
// Throughput: one request a cycle while results are taken; one stack update a cycle.
// Reset: the pool holds 256 blocks of 8 bytes, all free, in order 0 upwards;
// any configuration write rebuilds the free list in the same way at once.
module fixed_block_free_list_allocator
    import fbfl_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    fbfl_req_if.sink         request,
    fbfl_rsp_if.source       result,
    input  logic             cfg_we,
    input  cfg_index_t       cfg_index,
    input  logic [CFG_W-1:0] cfg_data
);

    // Configuration
    logic [BYTES_W-1:0]    block_bytes_reg;
    logic [BYTES_W-1:0]    block_bytes_next;
    logic [CNT_W-1:0]      block_count_reg;
    logic [CNT_W-1:0]      block_count_next;
    logic [CNT_W-1:0]      count;
    logic [STRIDE_W-1:0]   stride;

    // Input stage
    logic                  in_valid_reg;
    opcode_t               op_reg;
    logic [IDX_W-1:0]      idx_reg;

    // Free list state
    logic [CNT_W-1:0]      sp_reg;
    logic [CNT_W-1:0]      sp_next;
    logic [IDX_W-1:0]      top_reg;
    logic [IDX_W-1:0]      top_next;
    logic [MAX_BLOCKS-1:0] in_use_reg;
    logic [MAX_BLOCKS-1:0] in_use_next;
    logic [IDX_W-1:0]      below;
    stack_ctrl_t           sctrl;
    logic [CNT_W-1:0]      rd_full;

    // Result stage
    logic                  out_valid_reg;
    status_t               out_status_reg;
    logic [IDX_W-1:0]      out_index_reg;
    logic [OFFSET_W-1:0]   out_offset_reg;
    logic [CNT_W-1:0]      out_free_reg;
    status_t               status;
    logic [IDX_W-1:0]      gidx;
    logic [PROD_W-1:0]     product;
    logic [PROD_W-1:0]     offset_full;
    logic                  advance;

    assign count   = eff_count(block_count_reg);
    assign stride  = block_stride(block_bytes_reg);
    assign advance = in_valid_reg && (!out_valid_reg || result.ready);

    assign request.ready = !in_valid_reg || advance;

    // Configuration write decode
    always_comb
    begin
        block_bytes_next = block_bytes_reg;
        block_count_next = block_count_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_BLOCK_BYTES: block_bytes_next = cfg_data[BYTES_W-1:0];
                CFG_BLOCK_COUNT: block_count_next = cfg_data[CNT_W-1:0];
                default:         block_count_next = block_count_reg;
            endcase
        end
    end

    // Decide the request in the input stage and update the free list
    always_comb
    begin
        sp_next       = sp_reg;
        top_next      = top_reg;
        in_use_next   = in_use_reg;
        status        = ST_OK;
        gidx          = '0;
        sctrl.rebuild = 1'b0;
        sctrl.wr_en   = 1'b0;
        sctrl.wr_pos  = IDX_W'(sp_reg - CNT_W'(1));
        sctrl.wr_data = top_reg;
        sctrl.count   = count;
        if (advance)
        begin
            case (op_reg)
                OP_ALLOC:
                begin
                    if (sp_reg == '0)
                    begin
                        status = ST_EMPTY;
                    end
                    else
                    begin
                        gidx                 = top_reg;
                        in_use_next[top_reg] = 1'b1;
                        top_next             = below;
                        sp_next              = sp_reg - CNT_W'(1);
                    end
                end
                OP_FREE:
                begin
                    gidx = idx_reg;
                    if ({1'b0, idx_reg} >= count)
                    begin
                        status = ST_RANGE;
                    end
                    else if (!in_use_reg[idx_reg])
                    begin
                        status = ST_NOT_ALLOC;
                    end
                    else
                    begin
                        // Spill the old top below the new one
                        sctrl.wr_en          = (sp_reg != '0);
                        in_use_next[idx_reg] = 1'b0;
                        top_next             = idx_reg;
                        sp_next              = sp_reg + CNT_W'(1);
                    end
                end
                default:
                begin
                    status = ST_OK;
                end
            endcase
        end
        // A configuration write frees every block
        if (cfg_we)
        begin
            sctrl.rebuild = 1'b1;
            sctrl.wr_en   = 1'b0;
            sp_next       = eff_count(block_count_next);
            top_next      = '0;
            in_use_next   = '0;
        end
        // Keep the stack reading the entry that will sit under the top next cycle
        rd_full      = sp_next - CNT_W'(2);
        sctrl.rd_pos = rd_full[IDX_W-1:0];
    end

    // User area offset of the granted block
    assign product     = PROD_W'(gidx) * PROD_W'(stride);
    assign offset_full = (status == ST_OK) ? (USER_BASE + product) : '0;

    fbfl_stack u_stack
    (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (sctrl),
        .below (below)
    );

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_bytes_reg <= BYTES_W'(WORD_BYTES);
            block_count_reg <= CNT_W'(MAX_BLOCKS);
            sp_reg          <= CNT_W'(MAX_BLOCKS);
            top_reg         <= '0;
            in_use_reg      <= '0;
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            block_bytes_reg <= block_bytes_next;
            block_count_reg <= block_count_next;
            sp_reg          <= sp_next;
            top_reg         <= top_next;
            in_use_reg      <= in_use_next;
            if (request.ready)
            begin
                in_valid_reg <= request.valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (request.valid && request.ready)
        begin
            op_reg  <= request.opcode;
            idx_reg <= request.block_index;
        end
        if (advance)
        begin
            out_status_reg <= status;
            out_index_reg  <= gidx;
            out_offset_reg <= offset_full[OFFSET_W-1:0];
            out_free_reg   <= sp_next;
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.status        = out_status_reg;
    assign result.granted_index = out_index_reg;
    assign result.user_offset   = out_offset_reg;
    assign result.free_count    = out_free_reg;

    // The free count never exceeds the pool size
    assert property (@(posedge clk) disable iff (!rst_n) sp_reg <= count)
        else $error("free count above block count");

    // While any block is free, the top of the list is inside the pool
    assert property (@(posedge clk) disable iff (!rst_n)
        sp_reg != '0 |-> {1'b0, top_reg} < count)
        else $error("free list top outside the pool");

    // A granted allocation marks the block as in use and drops the count
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && op_reg == OP_ALLOC && sp_reg != '0 && !cfg_we
        |=> in_use_reg[$past(top_reg)] && sp_reg == $past(sp_reg) - CNT_W'(1))
        else $error("allocation did not take the top block");

endmodule

// File: src/fbfl_stack.sv
// Free list held as a stack of block indexes. The top entry lives in the
// allocator; this module stores the entries below it and always presents the
// one directly under the top. The read for the next cycle is issued every
// cycle, with a bypass when the same position is written in that cycle.
module fbfl_stack
    import fbfl_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  stack_ctrl_t      ctrl,
    output logic [IDX_W-1:0] below
);

    logic [IDX_W-1:0]      mem [MAX_BLOCKS];
    logic [MAX_BLOCKS-1:0] valid_reg;
    logic [MAX_BLOCKS-1:0] valid_next;
    logic [IDX_W-1:0]      rd_data_reg;
    logic                  rd_hit_reg;
    logic [IDX_W-1:0]      rd_dflt_reg;
    logic                  bypass_reg;
    logic                  bypass_next;
    logic [IDX_W-1:0]      bypass_data_reg;
    logic [IDX_W-1:0]      bypass_data_next;
    logic [CNT_W-1:0]      dflt_full;

    // An unwritten position p holds its rebuilt value count-1-p
    assign dflt_full = ctrl.count - CNT_W'(1) - {1'b0, ctrl.rd_pos};

    // Valid bits and bypass selection
    always_comb
    begin
        valid_next       = valid_reg;
        bypass_next      = 1'b0;
        bypass_data_next = ctrl.wr_data;
        if (ctrl.rebuild)
        begin
            valid_next       = '0;
            bypass_next      = 1'b1;
            bypass_data_next = IDX_W'(1);
        end
        else if (ctrl.wr_en)
        begin
            valid_next[ctrl.wr_pos] = 1'b1;
            bypass_next             = (ctrl.wr_pos == ctrl.rd_pos);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg       <= '0;
            bypass_reg      <= 1'b1;
            bypass_data_reg <= IDX_W'(1);
        end
        else
        begin
            valid_reg       <= valid_next;
            bypass_reg      <= bypass_next;
            bypass_data_reg <= bypass_data_next;
        end
    end

    // Stack memory: one write and one registered read a cycle
    always_ff @(posedge clk)
    begin
        if (ctrl.wr_en && !ctrl.rebuild)
        begin
            mem[ctrl.wr_pos] <= ctrl.wr_data;
        end
        rd_data_reg <= mem[ctrl.rd_pos];
        rd_hit_reg  <= valid_reg[ctrl.rd_pos];
        rd_dflt_reg <= dflt_full[IDX_W-1:0];
    end

    assign below = bypass_reg ? bypass_data_reg : (rd_hit_reg ? rd_data_reg : rd_dflt_reg);

endmodule

// File: tb/fixed_block_free_list_allocator_tb.sv
`timescale 1ns / 1ps

module fixed_block_free_list_allocator_tb;
    import fbfl_pkg::*;

    localparam int HOLD_CYCLES = 80;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed
    {
        opcode_t          op;
        logic [IDX_W-1:0] index;
    } pool_request_t;

    typedef struct packed
    {
        status_t             status;
        logic [IDX_W-1:0]    index;
        logic [OFFSET_W-1:0] offset;
        logic [CNT_W-1:0]    free_left;
    } alloc_result_t;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             cfg_we;
    cfg_index_t       cfg_index;
    logic [CFG_W-1:0] cfg_data;

    fbfl_req_if request_ch ();
    fbfl_rsp_if result_ch ();

    fixed_block_free_list_allocator dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .request   (request_ch),
        .result    (result_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Requests waiting to be offered and results still owed by the block.
    pool_request_t pending_reqs[$];
    alloc_result_t owed_results[$];

    // Shadow of the pool: geometry registers, free list and allocation flags.
    logic [BYTES_W-1:0] shadow_bytes;
    logic [CNT_W-1:0]   shadow_count;
    logic [CNT_W-1:0]   shadow_link [MAX_BLOCKS];
    logic               shadow_used [MAX_BLOCKS];
    logic [CNT_W-1:0]   shadow_head;
    logic [CNT_W-1:0]   shadow_free;

    int unsigned send_idle_pct = 36;
    int unsigned recv_idle_pct = 52;
    int unsigned hold_requests = 0;
    int unsigned hold_served = 0;
    int unsigned hold_left = 0;
    logic        req_taken = 1'b0;

    int unsigned failures = 0;
    int unsigned requests_taken = 0;
    int unsigned results_seen = 0;
    int unsigned config_writes = 0;
    int unsigned status_seen [4] = '{0, 0, 0, 0};

    pool_request_t next_req;
    pool_request_t taken_req;
    alloc_result_t seen_result;
    alloc_result_t want_result;

    // Clock: 20 ns period.
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Number of blocks actually in the pool after clamping the register.
    function automatic int unsigned pool_blocks();
        int unsigned c;
        c = shadow_count;
        if (c == 0)
        begin
            c = 1;
        end
        if (c > MAX_BLOCKS)
        begin
            c = MAX_BLOCKS;
        end
        return c;
    endfunction

    // Byte offset of the user area of a block, wrapped to the output width.
    function automatic logic [OFFSET_W-1:0] user_area_offset(input logic [IDX_W-1:0] idx);
        int unsigned area;
        int unsigned full;
        area = shadow_bytes;
        if (area > BYTES_LIMIT)
        begin
            area = BYTES_LIMIT;
        end
        area = ((area + WORD_BYTES - 1) / WORD_BYTES) * WORD_BYTES;
        full = HEADER_WORDS * WORD_BYTES + idx * (area + WORD_BYTES) + WORD_BYTES;
        return full[OFFSET_W-1:0];
    endfunction

    // Chain every block in ascending order and mark all of them free.
    function automatic void rebuild_free_list();
        int unsigned c;
        c = pool_blocks();
        for (int i = 0; i < MAX_BLOCKS; i++)
        begin
            shadow_link[i] = (i + 1 < c) ? CNT_W'(i + 1) : '0;
            shadow_used[i] = 1'b0;
        end
        shadow_head = '0;
        shadow_free = CNT_W'(c);
    endfunction

    // Apply one request to the shadow pool and return the result it should give.
    function automatic alloc_result_t apply_pool_request(input pool_request_t req);
        alloc_result_t res;
        logic [IDX_W-1:0] top;
        res = '0;
        res.status = ST_OK;
        if (req.op == OP_ALLOC)
        begin
            if (shadow_free == 0)
            begin
                res.status = ST_EMPTY;
            end
            else
            begin
                top = shadow_head[IDX_W-1:0];
                res.index = top;
                res.offset = user_area_offset(top);
                shadow_used[top] = 1'b1;
                shadow_head = shadow_link[top];
                shadow_free = shadow_free - 1'b1;
            end
        end
        else
        begin
            res.index = req.index;
            if (req.index >= pool_blocks())
            begin
                res.status = ST_RANGE;
            end
            else if (!shadow_used[req.index])
            begin
                res.status = ST_NOT_ALLOC;
            end
            else
            begin
                shadow_link[req.index] = shadow_head;
                shadow_head = CNT_W'(req.index);
                shadow_used[req.index] = 1'b0;
                shadow_free = shadow_free + 1'b1;
                res.offset = user_area_offset(req.index);
            end
        end
        res.free_left = shadow_free;
        return res;
    endfunction

    // Mostly allocations and frees of blocks held, with some frees of arbitrary
    // indices to hit the out-of-range and double-free paths.
    function automatic pool_request_t random_pool_request(input int unsigned alloc_pct);
        pool_request_t req;
        int unsigned roll;
        int unsigned start;
        int unsigned slot;
        bit found;
        roll = $urandom_range(99);
        req.op = OP_FREE;
        req.index = IDX_W'($urandom_range(MAX_BLOCKS - 1));
        found = 1'b0;
        if (roll < alloc_pct)
        begin
            req.op = OP_ALLOC;
        end
        else if (roll < alloc_pct + ((100 - alloc_pct) * 3) / 4)
        begin
            start = $urandom_range(MAX_BLOCKS - 1);
            for (int k = 0; k < MAX_BLOCKS; k++)
            begin
                slot = (start + k) % MAX_BLOCKS;
                if (!found && shadow_used[slot])
                begin
                    req.index = IDX_W'(slot);
                    found = 1'b1;
                end
            end
        end
        else if ($urandom_range(1) == 1)
        begin
            slot = $urandom_range(pool_blocks());
            req.index = IDX_W'(slot);
        end
        return req;
    endfunction

    task automatic add_request(input opcode_t op, input logic [IDX_W-1:0] index);
        pool_request_t req;
        req.op = op;
        req.index = index;
        pending_reqs.push_back(req);
    endtask

    // Wait until every queued request has gone in and every result has come out.
    task automatic wait_for_drain();
        while (pending_reqs.size() != 0 || request_ch.valid || owed_results.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Register writes happen only with the pool idle; any write rebuilds the list.
    task automatic write_register(input cfg_index_t which, input logic [CFG_W-1:0] value);
        wait_for_drain();
        repeat (3) @(posedge clk);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= which;
        cfg_data <= value;
        if (which == CFG_BLOCK_BYTES)
        begin
            shadow_bytes = value[BYTES_W-1:0];
        end
        else
        begin
            shadow_count = value[CNT_W-1:0];
        end
        rebuild_free_list();
        config_writes++;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Feed random requests a few at a time so that the frees track the shadow pool.
    task automatic run_random(input int unsigned total, input int unsigned alloc_pct,
                              input bit with_hold);
        int unsigned made;
        made = 0;
        while (made < total)
        begin
            while (pending_reqs.size() >= 4)
            begin
                @(negedge clk);
            end
            pending_reqs.push_back(random_pool_request(alloc_pct));
            made++;
            if (with_hold && made == total / 2)
            begin
                hold_requests++;
            end
        end
    endtask

    // Request driver: a new request is offered only once the previous one was taken.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            request_ch.valid <= 1'b0;
        end
        else if (!request_ch.valid || req_taken)
        begin
            if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                next_req = pending_reqs.pop_front();
                request_ch.valid <= 1'b1;
                request_ch.opcode <= next_req.op;
                request_ch.block_index <= next_req.index;
            end
            else
            begin
                request_ch.valid <= 1'b0;
            end
        end
    end

    // Result receiver: random stalls, plus a long hold-off when one is asked for.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            result_ch.ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_served != hold_requests)
        begin
            result_ch.ready <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_served <= hold_served + 1;
        end
        else
        begin
            result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Monitor: predict on each accepted request, check each accepted result.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            req_taken <= request_ch.valid && request_ch.ready;
            if (request_ch.valid && request_ch.ready)
            begin
                taken_req.op = request_ch.opcode;
                taken_req.index = request_ch.block_index;
                owed_results.push_back(apply_pool_request(taken_req));
                requests_taken++;
            end
            if (result_ch.valid && result_ch.ready)
            begin
                seen_result.status = result_ch.status;
                seen_result.index = result_ch.granted_index;
                seen_result.offset = result_ch.user_offset;
                seen_result.free_left = result_ch.free_count;
                results_seen++;
                if (owed_results.size() == 0)
                begin
                    if (failures < REPORT_LIMIT)
                    begin
                        $display("%0t: result with no request outstanding: status %0d index %0d",
                                 $realtime, seen_result.status, seen_result.index);
                    end
                    failures++;
                end
                else
                begin
                    want_result = owed_results.pop_front();
                    status_seen[want_result.status]++;
                    if (seen_result.status !== want_result.status
                        || seen_result.index !== want_result.index
                        || seen_result.offset !== want_result.offset
                        || seen_result.free_left !== want_result.free_left)
                    begin
                        if (failures < REPORT_LIMIT)
                        begin
                            $display("%0t: mismatch: expected status %0d index %0d offset %0d free %0d",
                                     $realtime, want_result.status, want_result.index,
                                     want_result.offset, want_result.free_left);
                            $display("%0t:          actual   status %0d index %0d offset %0d free %0d",
                                     $realtime, seen_result.status, seen_result.index,
                                     seen_result.offset, seen_result.free_left);
                        end
                        failures++;
                    end
                end
            end
        end
    end

    // Watchdog.
    initial
    begin
        #5_000_000;
        $display("Timed out with %0d requests queued and %0d results outstanding.",
                 pending_reqs.size(), owed_results.size());
        $display("CHECK FAILED");
        $finish;
    end

    // Stimulus sequence.
    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_BLOCK_BYTES;
        cfg_data = '0;
        request_ch.valid = 1'b0;
        request_ch.opcode = OP_ALLOC;
        request_ch.block_index = '0;
        result_ch.ready = 1'b0;
        shadow_bytes = BYTES_W'(8);
        shadow_count = CNT_W'(MAX_BLOCKS);
        rebuild_free_list();

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset geometry: allocate in order, free, double free, reuse of the head.
        add_request(OP_ALLOC, 8'hFF);
        add_request(OP_ALLOC, 8'h00);
        add_request(OP_ALLOC, 8'h55);
        add_request(OP_FREE, 8'd1);
        add_request(OP_FREE, 8'd1);
        add_request(OP_FREE, 8'd255);
        add_request(OP_ALLOC, 8'h00);
        add_request(OP_FREE, 8'd0);
        run_random(250, 50, 1'b0);

        // Two blocks: run the pool dry, then free out of range and twice.
        write_register(CFG_BLOCK_COUNT, CFG_W'(2));
        add_request(OP_ALLOC, 8'h00);
        add_request(OP_ALLOC, 8'hAA);
        add_request(OP_ALLOC, 8'hFF);
        add_request(OP_FREE, 8'd2);
        add_request(OP_FREE, 8'd255);
        add_request(OP_FREE, 8'd0);
        add_request(OP_FREE, 8'd0);
        add_request(OP_ALLOC, 8'h00);
        add_request(OP_FREE, 8'd1);
        run_random(150, 50, 1'b0);

        // Largest blocks in a full pool, biased to allocate up to the last index.
        write_register(CFG_BLOCK_BYTES, CFG_W'(4096));
        write_register(CFG_BLOCK_COUNT, CFG_W'(256));
        run_random(450, 80, 1'b1);

        send_idle_pct = 52;
        recv_idle_pct = 36;

        // Zero-sized user area and a zero count, which means a single block.
        write_register(CFG_BLOCK_BYTES, CFG_W'(0));
        write_register(CFG_BLOCK_COUNT, CFG_W'(0));
        run_random(150, 50, 1'b0);

        // Register values beyond the limits are clamped.
        write_register(CFG_BLOCK_BYTES, CFG_W'(8191));
        write_register(CFG_BLOCK_COUNT, CFG_W'(511));
        run_random(300, 65, 1'b1);

        send_idle_pct = 0;
        recv_idle_pct = 0;

        write_register(CFG_BLOCK_BYTES, CFG_W'(13));
        write_register(CFG_BLOCK_COUNT, CFG_W'(17));
        run_random(250, 55, 1'b0);

        // Bits above the count register's width are dropped.
        write_register(CFG_BLOCK_BYTES, CFG_W'(1));
        write_register(CFG_BLOCK_COUNT, CFG_W'(1));
        write_register(CFG_BLOCK_COUNT, CFG_W'(13'h1E05));
        run_random(200, 50, 1'b0);

        write_register(CFG_BLOCK_BYTES, CFG_W'(100));
        write_register(CFG_BLOCK_COUNT, CFG_W'(256));
        run_random(180, 60, 1'b0);

        wait_for_drain();
        repeat (4) @(posedge clk);

        $display("Covered %0d requests and %0d results across %0d register writes.",
                 requests_taken, results_seen, config_writes);
        $display("Results: %0d ok, %0d pool empty, %0d out of range, %0d not allocated; %0d mismatches.",
                 status_seen[ST_OK], status_seen[ST_EMPTY], status_seen[ST_RANGE],
                 status_seen[ST_NOT_ALLOC], failures);
        if (failures == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// File: filelist.f
src/fbfl_pkg.sv
src/fbfl_if.sv
src/fbfl_stack.sv
src/fixed_block_free_list_allocator.sv
tb/fixed_block_free_list_allocator_tb.sv
